@@ src/csf_pkg.sv @@
`timescale 1ns / 1ps

package csf_pkg;

    // input command codes
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // configuration register indexes
    localparam logic CFG_CHUNK_CHANNEL = 1'b0;
    localparam logic CFG_MAX_CHUNK     = 1'b1;

    // chunk header formats
    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_TYPE  = 2'd1;
    localparam logic [1:0] FMT_DELTA = 2'd2;
    localparam logic [1:0] FMT_NONE  = 2'd3;

    // job kinds passed from front to back
    localparam logic JOB_HEADER  = 1'b0;
    localparam logic JOB_PAYLOAD = 1'b1;

    // one unit of work for the serializer
    typedef struct packed {
        logic        kind;      // JOB_HEADER or JOB_PAYLOAD
        logic [1:0]  fmt;       // header format
        logic [23:0] ts;        // timestamp (format 0) or delta
        logic [23:0] len;
        logic [7:0]  ty;        // type id, or data byte for payload jobs
        logic [31:0] st;
        logic        zero_len;  // empty message: last header byte ends chunk
        logic        ins_hdr;   // payload: format-3 basic header goes first
        logic        end_flag;  // payload: data byte ends chunk
    } t_job;

    // index of the last byte a job emits
    function automatic logic [3:0] job_last(input t_job job);
        logic [3:0] v;
        v = 4'd0;
        if (job.kind == JOB_PAYLOAD) begin
            v = job.ins_hdr ? 4'd1 : 4'd0;
        end else begin
            unique case (job.fmt)
                FMT_FULL:  v = 4'd11;
                FMT_TYPE:  v = 4'd7;
                FMT_DELTA: v = 4'd3;
                FMT_NONE:  v = 4'd0;
                default:   v = 4'd0;
            endcase
        end
        return v;
    endfunction

endpackage

@@ src/csf_front.sv @@
`timescale 1ns / 1ps

module csf_front
    import csf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [23:0] i_msg_time,
    input  logic [23:0] i_msg_delta,
    input  logic [7:0]  i_msg_type,
    input  logic [31:0] i_msg_stream,
    input  logic [23:0] i_msg_length,
    input  logic        i_force_full,
    input  logic [7:0]  i_payload_byte,
    input  logic [23:0] i_max_chunk,
    output logic        o_push,
    output t_job        o_job,
    input  logic        i_q_ready
);

    logic [23:0] r_last_delta, r_last_length;
    logic [7:0]  r_last_type;
    logic [31:0] r_last_stream;
    logic [23:0] r_left, r_bic;

    logic        w_accept;
    logic        w_same_st, w_same_lt;
    logic [1:0]  w_fmt;
    logic [23:0] w_limit;
    logic        w_full;
    logic [23:0] n_bic, n_left;
    logic        w_end;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;

    // header classification
    assign w_same_st = !i_force_full && (r_last_stream == i_msg_stream);
    assign w_same_lt = w_same_st && (r_last_length == i_msg_length)
                       && (r_last_type == i_msg_type);

    always_comb begin
        if (w_same_lt && (r_last_delta == i_msg_delta)) begin
            w_fmt = FMT_NONE;
        end else if (w_same_lt) begin
            w_fmt = FMT_DELTA;
        end else if (w_same_st) begin
            w_fmt = FMT_TYPE;
        end else begin
            w_fmt = FMT_FULL;
        end
    end

    // payload chunking; a zero chunk size acts as one
    assign w_limit = (i_max_chunk == 24'd0) ? 24'd1 : i_max_chunk;
    assign w_full  = (r_bic >= w_limit);
    assign n_bic   = (w_full ? 24'd0 : r_bic) + 24'd1;
    assign n_left  = r_left - 24'd1;
    assign w_end   = (n_left == 24'd0) || (n_bic >= w_limit);

    always_comb begin
        o_job          = '0;
        o_job.kind     = i_command;
        o_job.fmt      = w_fmt;
        o_job.ts       = (w_fmt == FMT_FULL) ? i_msg_time : i_msg_delta;
        o_job.len      = i_msg_length;
        o_job.ty       = (i_command == CMD_PAYLOAD) ? i_payload_byte : i_msg_type;
        o_job.st       = i_msg_stream;
        o_job.zero_len = (i_msg_length == 24'd0);
        o_job.ins_hdr  = w_full;
        o_job.end_flag = w_end;
    end

    // payload with nothing due is dropped
    assign o_push = w_accept && ((i_command == CMD_HEADER) || (r_left != 24'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_delta  <= '0;
            r_last_length <= '0;
            r_last_type   <= '0;
            r_last_stream <= '0;
            r_left        <= '0;
            r_bic         <= '0;
        end else if (w_accept) begin
            if (i_command == CMD_HEADER) begin
                r_left <= i_msg_length;
                r_bic  <= '0;
                unique case (w_fmt)
                    FMT_DELTA: begin
                        r_last_delta <= i_msg_delta;
                    end
                    FMT_TYPE: begin
                        r_last_delta  <= i_msg_delta;
                        r_last_length <= i_msg_length;
                        r_last_type   <= i_msg_type;
                    end
                    FMT_FULL: begin
                        r_last_length <= i_msg_length;
                        r_last_type   <= i_msg_type;
                        r_last_stream <= i_msg_stream;
                    end
                    default: begin
                    end
                endcase
            end else if (r_left != 24'd0) begin
                r_left <= n_left;
                r_bic  <= n_bic;
            end
        end
    end

endmodule

@@ src/csf_queue.sv @@
`timescale 1ns / 1ps

module csf_queue
    import csf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/csf_back.sv @@
`timescale 1ns / 1ps

module csf_back
    import csf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_chunk_channel,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_header,
    output logic       o_chunk_end
);

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_idx, r_last;
    logic       r_ovalid, r_ohdr, r_oend;
    logic [7:0] r_obyte;

    logic       w_load, w_last_now;
    logic [7:0] w_byte;
    logic       w_hdr, w_end;

    assign w_load     = r_busy && (!r_ovalid || i_ready);
    assign w_last_now = w_load && (r_idx == r_last);
    assign o_pop      = i_q_valid && (!r_busy || w_last_now);

    // byte at the current position of the job
    always_comb begin
        w_byte = 8'd0;
        w_hdr  = 1'b1;
        w_end  = 1'b0;
        if (r_job.kind == JOB_PAYLOAD) begin
            if (r_idx == r_last) begin
                w_byte = r_job.ty;
                w_hdr  = 1'b0;
                w_end  = r_job.end_flag;
            end else begin
                w_byte = {FMT_NONE, i_chunk_channel};
            end
        end else begin
            w_end = r_job.zero_len && (r_idx == r_last);
            case (r_idx)
                4'd0:    w_byte = {r_job.fmt, i_chunk_channel};
                4'd1:    w_byte = r_job.ts[23:16];
                4'd2:    w_byte = r_job.ts[15:8];
                4'd3:    w_byte = r_job.ts[7:0];
                4'd4:    w_byte = r_job.len[23:16];
                4'd5:    w_byte = r_job.len[15:8];
                4'd6:    w_byte = r_job.len[7:0];
                4'd7:    w_byte = r_job.ty;
                4'd8:    w_byte = r_job.st[7:0];
                4'd9:    w_byte = r_job.st[15:8];
                4'd10:   w_byte = r_job.st[23:16];
                4'd11:   w_byte = r_job.st[31:24];
                default: w_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_q_job;
            r_last <= job_last(i_q_job);
        end
        if (w_load) begin
            r_obyte <= w_byte;
            r_ohdr  <= w_hdr;
            r_oend  <= w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (w_last_now) begin
                r_busy <= 1'b0;
            end else if (w_load) begin
                r_idx <= r_idx + 4'd1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_is_header = r_ohdr;
    assign o_chunk_end = r_oend;

endmodule

@@ src/chunk_stream_framer_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// input     in   i_valid / o_ready    i_command, i_msg_*, i_force_full, i_payload_byte
// output    out  o_valid / i_ready    o_out_byte, o_is_header, o_chunk_end
// config    in   i_cfg_we             i_cfg_index, i_cfg_data
//
// Items are accepted one per cycle while the two-entry job queue has room.
// A header item emits 12, 8, 4 or 1 bytes (format 0..3), one per cycle while
// i_ready holds, on the output register; a payload item emits 1 byte, or 2 when
// a format-3 basic header opens a new chunk. The back-end serializer sets the rate.
// Reset (synchronous, active low) empties the queue and output register and
// clears the remembered header fields. Either side may stall independently.

module chunk_stream_framer_top
    import csf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [23:0] i_msg_time,
    input  logic [23:0] i_msg_delta,
    input  logic [7:0]  i_msg_type,
    input  logic [31:0] i_msg_stream,
    input  logic [23:0] i_msg_length,
    input  logic        i_force_full,
    input  logic [7:0]  i_payload_byte,
    // output items
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_header,
    output logic        o_chunk_end,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [5:0]  r_chunk_channel;
    logic [23:0] r_max_chunk;

    logic w_push, w_q_ready, w_q_valid, w_pop;
    t_job w_front_job, w_q_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_channel <= 6'd3;
            r_max_chunk     <= 24'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHUNK_CHANNEL: r_chunk_channel <= i_cfg_data[5:0];
                CFG_MAX_CHUNK:     r_max_chunk     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: accept, pick header format, track chunk position
    csf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_msg_time     (i_msg_time),
        .i_msg_delta    (i_msg_delta),
        .i_msg_type     (i_msg_type),
        .i_msg_stream   (i_msg_stream),
        .i_msg_length   (i_msg_length),
        .i_force_full   (i_force_full),
        .i_payload_byte (i_payload_byte),
        .i_max_chunk    (r_max_chunk),
        .o_push         (w_push),
        .o_job          (w_front_job),
        .i_q_ready      (w_q_ready)
    );

    // job queue decouples the two sides
    csf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_pop)
    );

    // back: serialize jobs into framed bytes
    csf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_chunk_channel (r_chunk_channel),
        .i_q_valid       (w_q_valid),
        .i_q_job         (w_q_job),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_is_header     (o_is_header),
        .o_chunk_end     (o_chunk_end)
    );

    // reset leaves nothing pending on either side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !w_q_valid))
        else $error("output or queue not empty after reset");

    // every accepted header item becomes a job
    a_header_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_command == CMD_HEADER)) |-> w_push)
        else $error("header item dropped");

    // back never pops an empty queue into a new job
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

endmodule
